FILE: rtl/dpif_pkg.sv
// Shared types, codes and default sizes for the dual pool index free list.
package dpif_pkg;

	localparam int IDX_W    = 21;
	localparam int MODE_W   = 3;
	localparam int STATUS_W = 2;

	localparam logic [MODE_W-1:0] MODE_ALLOC_TEX = 3'd0;
	localparam logic [MODE_W-1:0] MODE_ALLOC_BUF = 3'd1;
	localparam logic [MODE_W-1:0] MODE_FREE_TEX  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_FREE_BUF  = 3'd3;
	localparam logic [MODE_W-1:0] MODE_REFILL    = 3'd4;

	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;
	localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd3;

	localparam int TEXTURE_BASE_DEF      = 0;
	localparam int TEXTURE_POOL_SIZE_DEF = 1024;
	localparam int BUFFER_BASE_DEF       = 1024;
	localparam int BUFFER_POOL_SIZE_DEF  = 1024;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [IDX_W-1:0]  free_index;
	} req_t;

	typedef struct packed {
		logic [IDX_W-1:0]    given_index;
		logic [STATUS_W-1:0] status;
		logic [IDX_W-1:0]    textures_in_use;
		logic [IDX_W-1:0]    buffers_in_use;
		logic [IDX_W-1:0]    textures_available;
		logic [IDX_W-1:0]    buffers_available;
	} rsp_t;

	typedef struct packed {
		logic alloc;
		logic release_idx;
		logic refill;
	} pool_cmd_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [IDX_W-1:0]    index;
		logic [IDX_W-1:0]    in_use;
		logic [IDX_W-1:0]    available;
	} pool_rsp_t;

	typedef struct packed {
		logic capture;
		logic exec;
	} ctrl_cmd_t;

endpackage

FILE: rtl/dpif_ifs.sv
// Request and response channel interfaces of the dual pool index free list.
interface dpif_req_if;
	import dpif_pkg::*;
	logic valid;
	logic ready;
	req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface dpif_rsp_if;
	import dpif_pkg::*;
	logic valid;
	logic ready;
	rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/dpif_pool.sv
// One free stack of indices with its depth, low-water mark and stack memory.
module dpif_pool #(
	parameter int BASE = dpif_pkg::TEXTURE_BASE_DEF,
	parameter int SIZE = dpif_pkg::TEXTURE_POOL_SIZE_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  dpif_pkg::pool_cmd_t         cmd,
	input  logic [dpif_pkg::IDX_W-1:0]  free_index,
	output dpif_pkg::pool_rsp_t         rsp
);
	import dpif_pkg::*;

	localparam int DW = $clog2(SIZE + 1);
	localparam int AW = (SIZE > 1) ? $clog2(SIZE) : 1;
	localparam logic [IDX_W:0] LO = (IDX_W + 1)'(BASE);
	localparam logic [IDX_W:0] HI = (IDX_W + 1)'(BASE + SIZE - 1);

	logic [IDX_W-1:0] mem [SIZE];
	logic [IDX_W-1:0] rd_data_q;
	logic [DW-1:0]    depth_q, depth_nx;
	logic [DW-1:0]    mark_q, mark_nx;
	logic [DW-1:0]    pos;
	logic             empty, full, in_range, we;

	assign pos      = depth_q - DW'(1);
	assign empty    = (depth_q == '0);
	assign full     = (depth_q == DW'(SIZE));
	assign in_range = ({1'b0, free_index} >= LO) && ({1'b0, free_index} <= HI);

	always_comb begin
		depth_nx   = depth_q;
		mark_nx    = mark_q;
		we         = 1'b0;
		rsp.status = STATUS_OK;
		rsp.index  = '0;
		if (cmd.refill) begin
			depth_nx = DW'(SIZE);
			mark_nx  = DW'(SIZE);
		end else if (cmd.alloc) begin
			if (empty) begin
				rsp.status = STATUS_EMPTY;
			end else begin
				depth_nx = pos;
				// Slots below the mark were never pushed and hold base plus position.
				if (pos < mark_q) begin
					rsp.index = IDX_W'(BASE) + IDX_W'(pos);
				end else begin
					rsp.index = rd_data_q;
				end
			end
		end else if (cmd.release_idx) begin
			if (!in_range) begin
				rsp.status = STATUS_RANGE;
			end else if (full) begin
				rsp.status = STATUS_FULL;
			end else begin
				we       = 1'b1;
				depth_nx = depth_q + DW'(1);
				if (depth_q < mark_q) begin
					mark_nx = depth_q;
				end
			end
		end
		rsp.in_use    = IDX_W'(SIZE) - IDX_W'(depth_nx);
		rsp.available = IDX_W'(depth_nx);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= DW'(SIZE);
			mark_q  <= DW'(SIZE);
		end else begin
			depth_q <= depth_nx;
			mark_q  <= mark_nx;
		end
	end

	// The top entry is read every cycle, so it is ready in the cycle after capture.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[depth_q[AW-1:0]] <= free_index;
		end
		rd_data_q <= mem[pos[AW-1:0]];
	end

endmodule

FILE: rtl/dpif_datapath.sv
// Request register, both pools and the result register.
module dpif_datapath #(
	parameter int TEXTURE_BASE      = dpif_pkg::TEXTURE_BASE_DEF,
	parameter int TEXTURE_POOL_SIZE = dpif_pkg::TEXTURE_POOL_SIZE_DEF,
	parameter int BUFFER_BASE       = dpif_pkg::BUFFER_BASE_DEF,
	parameter int BUFFER_POOL_SIZE  = dpif_pkg::BUFFER_POOL_SIZE_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  dpif_pkg::ctrl_cmd_t cmd,
	input  dpif_pkg::req_t      req_data,
	output dpif_pkg::rsp_t      rsp_data
);
	import dpif_pkg::*;

	req_t      req_q;
	rsp_t      rsp_q;
	pool_cmd_t tex_cmd, buf_cmd;
	pool_rsp_t tex_rsp, buf_rsp;
	logic [STATUS_W-1:0] status;
	logic [IDX_W-1:0]    given;

	always_comb begin
		tex_cmd = '0;
		buf_cmd = '0;
		status  = STATUS_OK;
		given   = '0;
		unique case (req_q.mode)
			MODE_ALLOC_TEX: begin
				tex_cmd.alloc = cmd.exec;
				status        = tex_rsp.status;
				given         = tex_rsp.index;
			end
			MODE_ALLOC_BUF: begin
				buf_cmd.alloc = cmd.exec;
				status        = buf_rsp.status;
				given         = buf_rsp.index;
			end
			MODE_FREE_TEX: begin
				tex_cmd.release_idx = cmd.exec;
				status              = tex_rsp.status;
			end
			MODE_FREE_BUF: begin
				buf_cmd.release_idx = cmd.exec;
				status              = buf_rsp.status;
			end
			MODE_REFILL: begin
				tex_cmd.refill = cmd.exec;
				buf_cmd.refill = cmd.exec;
			end
			default: begin
			end
		endcase
	end

	dpif_pool #(.BASE(TEXTURE_BASE), .SIZE(TEXTURE_POOL_SIZE)) u_tex_pool (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (tex_cmd),
		.free_index (req_q.free_index),
		.rsp        (tex_rsp)
	);

	dpif_pool #(.BASE(BUFFER_BASE), .SIZE(BUFFER_POOL_SIZE)) u_buf_pool (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (buf_cmd),
		.free_index (req_q.free_index),
		.rsp        (buf_rsp)
	);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= req_data;
		end
		if (cmd.exec) begin
			rsp_q.given_index        <= given;
			rsp_q.status             <= status;
			rsp_q.textures_in_use    <= tex_rsp.in_use;
			rsp_q.buffers_in_use     <= buf_rsp.in_use;
			rsp_q.textures_available <= tex_rsp.available;
			rsp_q.buffers_available  <= buf_rsp.available;
		end
	end

	assign rsp_data = rsp_q;

endmodule

FILE: rtl/dpif_ctrl.sv
// Controller that sequences capture, execution and delivery of one request.
module dpif_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                out_ready,
	output logic                in_ready,
	output logic                out_valid,
	output dpif_pkg::ctrl_cmd_t cmd
);
	import dpif_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_OUT  = 2'd2;

	logic [1:0] state_q, state_nx;

	assign in_ready    = (state_q == ST_IDLE);
	assign out_valid   = (state_q == ST_OUT);
	assign cmd.capture = in_ready && in_valid;
	assign cmd.exec    = (state_q == ST_EXEC);

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_nx = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_nx = ST_OUT;
			end
			ST_OUT: begin
				if (out_ready) begin
					state_nx = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

endmodule

FILE: rtl/dual_pool_index_free_list_unit.sv
// Top level of the dual pool index free list: texture and buffer index stacks.
//
//   channel  role    beat content
//   req      sink    mode, free_index
//   rsp      source  given_index, status, in-use and available counts of both pools
//
// A request passes through capture with the stack top read, execution, then the
// result beat; execution is a step of its own because of the registered read port of
// the stack memory. A stalled result holds the block, and no new request is taken
// until it is delivered. After reset both pools are full and no clearing pass is
// needed, since the low-water mark stands for the initial contents.
module dual_pool_index_free_list_unit #(
	parameter int TEXTURE_BASE      = dpif_pkg::TEXTURE_BASE_DEF,
	parameter int TEXTURE_POOL_SIZE = dpif_pkg::TEXTURE_POOL_SIZE_DEF,
	parameter int BUFFER_BASE       = dpif_pkg::BUFFER_BASE_DEF,
	parameter int BUFFER_POOL_SIZE  = dpif_pkg::BUFFER_POOL_SIZE_DEF
) (
	input logic      clk,
	input logic      arst_n,
	dpif_req_if.sink   req,
	dpif_rsp_if.source rsp
);
	import dpif_pkg::*;

	ctrl_cmd_t cmd;

	dpif_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.out_ready (rsp.ready),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.cmd       (cmd)
	);

	dpif_datapath #(
		.TEXTURE_BASE      (TEXTURE_BASE),
		.TEXTURE_POOL_SIZE (TEXTURE_POOL_SIZE),
		.BUFFER_BASE       (BUFFER_BASE),
		.BUFFER_POOL_SIZE  (BUFFER_POOL_SIZE)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.req_data (req.data),
		.rsp_data (rsp.data)
	);

endmodule

FILE: rtl/dpif_checker.sv
// Port-level checks of the dual pool index free list and their binding.
module dpif_checker #(
	parameter int TEXTURE_POOL_SIZE = dpif_pkg::TEXTURE_POOL_SIZE_DEF,
	parameter int BUFFER_POOL_SIZE  = dpif_pkg::BUFFER_POOL_SIZE_DEF
) (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_ready,
	input logic           rsp_valid,
	input logic           rsp_ready,
	input dpif_pkg::rsp_t rsp_data
);
	import dpif_pkg::*;

	// Every index of a pool is either allocated or on its free stack.
	a_tex_balance: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> ({1'b0, rsp_data.textures_in_use} + {1'b0, rsp_data.textures_available})
			== (IDX_W + 1)'(TEXTURE_POOL_SIZE))
		else $error("texture counts do not add up to the pool size");

	a_buf_balance: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> ({1'b0, rsp_data.buffers_in_use} + {1'b0, rsp_data.buffers_available})
			== (IDX_W + 1)'(BUFFER_POOL_SIZE))
		else $error("buffer counts do not add up to the pool size");

	a_err_zero_index: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_data.status != STATUS_OK) |-> (rsp_data.given_index == '0))
		else $error("failed request returned a nonzero index");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("second request taken while one is in progress");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("stalled result beat changed or dropped");

endmodule

bind dual_pool_index_free_list_unit dpif_checker #(
	.TEXTURE_POOL_SIZE (TEXTURE_POOL_SIZE),
	.BUFFER_POOL_SIZE  (BUFFER_POOL_SIZE)
) u_dpif_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);

FILE: bench/dual_pool_index_free_list_unit_tb.sv
// Self-checking bench for the dual pool index free list: stack model, stimulus and checks.
`timescale 1ns / 1ps

import dpif_pkg::*;

typedef enum int {
	TEXTURE_POOL = 0,
	BUFFER_POOL  = 1
} pool_sel_e;

typedef enum int {
	STALL_NONE,
	STALL_RANDOM,
	STALL_PATTERN,
	STALL_HEAVY
} stall_style_e;

class free_list_scoreboard;
	localparam int SLOTS = (TEXTURE_POOL_SIZE_DEF > BUFFER_POOL_SIZE_DEF) ?
		TEXTURE_POOL_SIZE_DEF : BUFFER_POOL_SIZE_DEF;

	logic [IDX_W-1:0] slot [2][SLOTS];
	int unsigned depth [2];
	int unsigned low_mark [2];
	int unsigned base [2];
	int unsigned size [2];

	// Indices handed out and not yet returned; the driver frees from these.
	logic [IDX_W-1:0] held_tex [$];
	logic [IDX_W-1:0] held_buf [$];

	rsp_t pending_rsp [$];

	int requests;
	int responses;
	int mismatches;
	int allocs_ok;
	int frees_ok;
	int empties;
	int range_errors;
	int fulls;
	int refills;

	function new();
		base[TEXTURE_POOL] = TEXTURE_BASE_DEF;
		size[TEXTURE_POOL] = TEXTURE_POOL_SIZE_DEF;
		base[BUFFER_POOL]  = BUFFER_BASE_DEF;
		size[BUFFER_POOL]  = BUFFER_POOL_SIZE_DEF;
		refill_pools();
	endfunction

	function void refill_pools();
		for (int p = 0; p < 2; p++) begin
			depth[p]    = size[p];
			low_mark[p] = size[p];
		end
		held_tex.delete();
		held_buf.delete();
	endfunction

	function int held_count(pool_sel_e p);
		return (p == TEXTURE_POOL) ? held_tex.size() : held_buf.size();
	endfunction

	function logic [IDX_W-1:0] pick_held(pool_sel_e p);
		if (p == TEXTURE_POOL)
			return held_tex[$urandom_range(0, held_tex.size() - 1)];
		return held_buf[$urandom_range(0, held_buf.size() - 1)];
	endfunction

	function void pop_index(pool_sel_e p, output logic [STATUS_W-1:0] st,
			output logic [IDX_W-1:0] idx);
		int unsigned pos;
		idx = '0;
		if (depth[p] == 0) begin
			st = STATUS_EMPTY;
			return;
		end
		depth[p]--;
		pos = depth[p];
		// Slots under the low-water mark were never overwritten since the last refill.
		if (pos < low_mark[p])
			idx = IDX_W'(base[p] + pos);
		else
			idx = slot[p][pos];
		st = STATUS_OK;
		if (p == TEXTURE_POOL)
			held_tex.insert(held_tex.size(), idx);
		else
			held_buf.insert(held_buf.size(), idx);
	endfunction

	function void push_index(pool_sel_e p, logic [IDX_W-1:0] idx,
			output logic [STATUS_W-1:0] st);
		longint unsigned lo;
		longint unsigned hi;
		int unsigned pos;
		lo = base[p];
		hi = longint'(base[p]) + longint'(size[p]) - 1;
		if (idx < lo || idx > hi) begin
			st = STATUS_RANGE;
			return;
		end
		if (depth[p] >= size[p]) begin
			st = STATUS_FULL;
			return;
		end
		pos = depth[p];
		slot[p][pos] = idx;
		if (pos < low_mark[p])
			low_mark[p] = pos;
		depth[p] = pos + 1;
		st = STATUS_OK;
		if (p == TEXTURE_POOL) begin
			foreach (held_tex[i]) if (held_tex[i] == idx) begin
				held_tex.delete(i);
				break;
			end
		end else begin
			foreach (held_buf[i]) if (held_buf[i] == idx) begin
				held_buf.delete(i);
				break;
			end
		end
	endfunction

	function void note_request(req_t r);
		rsp_t e;
		logic [STATUS_W-1:0] st;
		logic [IDX_W-1:0] idx;
		e = '0;
		st = STATUS_OK;
		idx = '0;
		case (r.mode)
			MODE_ALLOC_TEX: pop_index(TEXTURE_POOL, st, idx);
			MODE_ALLOC_BUF: pop_index(BUFFER_POOL, st, idx);
			MODE_FREE_TEX:  push_index(TEXTURE_POOL, r.free_index, st);
			MODE_FREE_BUF:  push_index(BUFFER_POOL, r.free_index, st);
			MODE_REFILL: begin
				refill_pools();
				refills++;
			end
			default: ;
		endcase
		case (st)
			STATUS_EMPTY: empties++;
			STATUS_RANGE: range_errors++;
			STATUS_FULL:  fulls++;
			default: begin
				if (r.mode == MODE_ALLOC_TEX || r.mode == MODE_ALLOC_BUF)
					allocs_ok++;
				else if (r.mode == MODE_FREE_TEX || r.mode == MODE_FREE_BUF)
					frees_ok++;
			end
		endcase
		e.given_index        = idx;
		e.status             = st;
		e.textures_in_use    = IDX_W'(size[TEXTURE_POOL] - depth[TEXTURE_POOL]);
		e.buffers_in_use     = IDX_W'(size[BUFFER_POOL] - depth[BUFFER_POOL]);
		e.textures_available = IDX_W'(depth[TEXTURE_POOL]);
		e.buffers_available  = IDX_W'(depth[BUFFER_POOL]);
		pending_rsp.insert(pending_rsp.size(), e);
		requests++;
	endfunction

	task report_mismatch(string msg);
		mismatches++;
		$display("ERROR at %0t ns: %s", $time, msg);
	endtask

	task check_field(string name, logic [IDX_W-1:0] got, logic [IDX_W-1:0] want);
		if (got !== want)
			report_mismatch($sformatf("response %0d %s: got %0d, expected %0d",
				responses, name, got, want));
	endtask

	task check_response(rsp_t got);
		rsp_t e;
		if (pending_rsp.size() == 0) begin
			report_mismatch($sformatf("response beat with no request outstanding: %h", got));
			return;
		end
		e = pending_rsp.pop_front();
		check_field("given_index", got.given_index, e.given_index);
		check_field("status", IDX_W'(got.status), IDX_W'(e.status));
		check_field("textures_in_use", got.textures_in_use, e.textures_in_use);
		check_field("buffers_in_use", got.buffers_in_use, e.buffers_in_use);
		check_field("textures_available", got.textures_available, e.textures_available);
		check_field("buffers_available", got.buffers_available, e.buffers_available);
		responses++;
	endtask
endclass

module dual_pool_index_free_list_unit_tb;
	localparam int TEX_BASE = TEXTURE_BASE_DEF;
	localparam int TEX_TOP  = TEXTURE_BASE_DEF + TEXTURE_POOL_SIZE_DEF - 1;
	localparam int BUF_BASE = BUFFER_BASE_DEF;
	localparam int BUF_TOP  = BUFFER_BASE_DEF + BUFFER_POOL_SIZE_DEF - 1;

	localparam logic [MODE_W-1:0] MODE_UNUSED_LO = 3'd5;
	localparam logic [MODE_W-1:0] MODE_UNUSED_HI = 3'd7;

	logic clk;
	logic arst_n;

	dpif_req_if req_bus ();
	dpif_rsp_if rsp_bus ();

	dual_pool_index_free_list_unit #(
		.TEXTURE_BASE     (TEXTURE_BASE_DEF),
		.TEXTURE_POOL_SIZE(TEXTURE_POOL_SIZE_DEF),
		.BUFFER_BASE      (BUFFER_BASE_DEF),
		.BUFFER_POOL_SIZE (BUFFER_POOL_SIZE_DEF)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_bus.sink),
		.rsp   (rsp_bus.source)
	);

	free_list_scoreboard sb;
	int burst_left;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#40000000;
		$display("Mismatches found");
		$finish;
	end

	// Response side: the stall style changes every so often, including long open stretches.
	initial begin
		stall_style_e style;
		int style_left;
		int phase;
		logic [7:0] mask;
		style_left = 0;
		phase = 0;
		mask = 8'hff;
		style = STALL_NONE;
		rsp_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (style_left == 0) begin
				style = stall_style_e'($urandom_range(0, 3));
				style_left = $urandom_range(20, 200);
				mask = 8'($urandom_range(1, 255));
			end
			style_left--;
			phase++;
			case (style)
				STALL_NONE:    rsp_bus.ready <= 1'b1;
				STALL_RANDOM:  rsp_bus.ready <= ($urandom_range(0, 99) >= 30);
				STALL_PATTERN: rsp_bus.ready <= mask[phase % 8];
				default:       rsp_bus.ready <= ($urandom_range(0, 15) == 0);
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
			sb.check_response(rsp_bus.data);
	end

	// One request beat; the sender sometimes idles between bursts of random length.
	task send_item(logic [MODE_W-1:0] mode, logic [IDX_W-1:0] idx);
		req_t item;
		int gap;
		item.mode = mode;
		item.free_index = idx;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				req_bus.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		req_bus.valid <= 1'b1;
		req_bus.data <= item;
		do @(posedge clk); while (req_bus.ready !== 1'b1);
		sb.note_request(item);
	endtask

	function logic [IDX_W-1:0] any_index();
		return IDX_W'($urandom());
	endfunction

	function logic [IDX_W-1:0] index_in(pool_sel_e p);
		return (p == TEXTURE_POOL) ? IDX_W'($urandom_range(TEX_BASE, TEX_TOP)) :
			IDX_W'($urandom_range(BUF_BASE, BUF_TOP));
	endfunction

	task alloc_from(pool_sel_e p);
		send_item((p == TEXTURE_POOL) ? MODE_ALLOC_TEX : MODE_ALLOC_BUF, any_index());
	endtask

	task free_into(pool_sel_e p, logic [IDX_W-1:0] idx);
		send_item((p == TEXTURE_POOL) ? MODE_FREE_TEX : MODE_FREE_BUF, idx);
	endtask

	// Returns an index that is out, or an arbitrary in-range one when none is out.
	task free_held(pool_sel_e p);
		if (sb.held_count(p) > 0)
			free_into(p, sb.pick_held(p));
		else
			free_into(p, index_in(p));
	endtask

	task noise_item(bit allow_refill);
		pool_sel_e p;
		p = pool_sel_e'($urandom_range(0, 1));
		case ($urandom_range(0, 5))
			0: send_item(MODE_W'($urandom_range(0, MODE_UNUSED_HI)), any_index());
			1: free_into(p, index_in(p));
			2: case ($urandom_range(0, 2))
				0: free_into(BUFFER_POOL, IDX_W'(BUF_BASE - 1));
				1: free_into(p, IDX_W'((p == TEXTURE_POOL) ? TEX_TOP + 1 : BUF_TOP + 1));
				default: free_into(p, IDX_W'($urandom_range(BUF_TOP + 1, (1 << IDX_W) - 1)));
			endcase
			3: if (allow_refill)
				send_item(MODE_REFILL, any_index());
			else
				alloc_from(p);
			4: send_item(MODE_W'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI)), any_index());
			default: free_held(pool_sel_e'(1 - int'(p)));
		endcase
	endtask

	// Allocate a pool dry, knock on the empty pool, cycle part of it back through, then refill both.
	task drain_pool(pool_sel_e p);
		int k;
		while (sb.depth[p] > 0) begin
			if ($urandom_range(0, 9) == 0)
				noise_item(1'b0);
			else
				alloc_from(p);
		end
		repeat ($urandom_range(1, 3)) alloc_from(p);
		k = $urandom_range(10, 60);
		repeat (k) free_held(p);
		repeat (k / 2 + $urandom_range(0, k)) alloc_from(p);
		send_item(MODE_REFILL, any_index());
	endtask

	task mixed_traffic(int count);
		int stop;
		int alloc_pct;
		pool_sel_e p;
		stop = sb.requests + count;
		alloc_pct = 50;
		while (sb.requests < stop) begin
			if (sb.requests % 50 == 0)
				alloc_pct = $urandom_range(30, 85);
			p = pool_sel_e'($urandom_range(0, 1));
			if ($urandom_range(0, 59) == 0)
				send_item(MODE_REFILL, any_index());
			else if ($urandom_range(0, 99) < 15)
				noise_item(1'b1);
			else if (sb.held_count(p) > 0 && $urandom_range(0, 99) >= alloc_pct)
				free_held(p);
			else
				alloc_from(p);
		end
	endtask

	initial begin
		int drain_wait;
		sb = new();
		burst_left = 0;
		arst_n = 1'b0;
		req_bus.valid <= 1'b0;
		req_bus.data <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Both pools start full, so in-range frees are rejected until something is taken.
		free_into(TEXTURE_POOL, IDX_W'(TEX_BASE + 5));
		free_into(BUFFER_POOL, IDX_W'(BUF_BASE));
		free_into(BUFFER_POOL, IDX_W'(BUF_TOP));
		free_into(TEXTURE_POOL, IDX_W'(TEX_TOP + 1));
		free_into(BUFFER_POOL, IDX_W'(BUF_BASE - 1));
		free_into(BUFFER_POOL, IDX_W'(BUF_TOP + 1));
		free_into(TEXTURE_POOL, '1);
		send_item(MODE_ALLOC_TEX, '1);
		send_item(MODE_ALLOC_BUF, '0);
		free_into(TEXTURE_POOL, IDX_W'(TEX_BASE));
		alloc_from(TEXTURE_POOL);
		alloc_from(TEXTURE_POOL);
		// The same index goes back twice; the second push is taken as a normal free.
		free_into(TEXTURE_POOL, IDX_W'(TEX_TOP - 1));
		free_into(TEXTURE_POOL, IDX_W'(TEX_TOP - 1));
		free_into(TEXTURE_POOL, IDX_W'(TEX_BASE + 3));
		for (int m = MODE_UNUSED_LO; m <= MODE_UNUSED_HI; m++)
			send_item(MODE_W'(m), any_index());
		send_item(MODE_REFILL, '1);
		alloc_from(BUFFER_POOL);
		free_into(BUFFER_POOL, IDX_W'(BUF_BASE));
		alloc_from(BUFFER_POOL);
		free_into(BUFFER_POOL, IDX_W'(TEX_TOP));
		free_into(TEXTURE_POOL, IDX_W'(BUF_BASE));
		send_item(MODE_REFILL, '0);

		drain_pool(TEXTURE_POOL);
		mixed_traffic(150);

		req_bus.valid <= 1'b0;
		drain_wait = 0;
		while (sb.pending_rsp.size() > 0 && drain_wait < 100000) begin
			@(posedge clk);
			drain_wait++;
		end
		repeat (10) @(posedge clk);
		if (sb.pending_rsp.size() > 0)
			sb.report_mismatch($sformatf("%0d responses never arrived", sb.pending_rsp.size()));

		$display("Covered %0d requests and %0d responses: %0d allocations, %0d frees, %0d refills.",
			sb.requests, sb.responses, sb.allocs_ok, sb.frees_ok, sb.refills);
		$display("Rejections seen: %0d empty pool, %0d out of range, %0d full pool.",
			sb.empties, sb.range_errors, sb.fulls);
		if (sb.mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
